// ===== hdl/r12_pkg.sv =====
// shared types and constants for the raw12 unpack plane router
package r12_pkg;

   // fixed field widths
   localparam int BYTE_BITS  = 8;
   localparam int NIB_BITS   = 4;
   localparam int PIX_BITS   = 12;
   localparam int COL_BITS   = 12;
   localparam int GRP_BITS   = 12;
   localparam int STEP_BITS  = 4;
   localparam int DEST_BITS  = 20;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 20;

   // register indexes on the csr port
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IR_BASE     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LINE_GROUPS = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEPBACK    = 3'd4;

   // smallest usable row width in alternating mode
   localparam logic [COL_BITS-1:0] MIN_WIDTH = 12'd2;

   typedef enum logic [1:0] {
      MODE_DEPTH = 2'd0,
      MODE_IR    = 2'd1,
      MODE_ALT   = 2'd2,
      MODE_RAW   = 2'd3
   } mode_type;

   // configuration as seen by the index unit
   typedef struct packed {
      mode_type               mode;
      logic [COL_BITS-1:0]    frame_width;
      logic [DEST_BITS-1:0]   ir_plane_base;
      logic [GRP_BITS-1:0]    raw_line_groups;
      logic [STEP_BITS-1:0]   raw_stepback;
   } cfg_type;

   // destination chosen for one item
   typedef struct packed {
      logic                  plane;
      logic [DEST_BITS-1:0]  dest_index;
   } route_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] byte_a;
      logic [BYTE_BITS-1:0] byte_b;
      logic [BYTE_BITS-1:0] byte_c;
      logic                 frame_start;
   } req_item_type;

   typedef struct packed {
      logic [PIX_BITS-1:0]  pixel_first;
      logic [PIX_BITS-1:0]  pixel_second;
      logic                 plane;
      logic [DEST_BITS-1:0] dest_index;
   } rsp_item_type;

endpackage

// ===== hdl/r12_unpack_lane.sv =====
// one pixel lane: joins an upper byte and a nibble into a 12-bit pixel
module r12_unpack_lane
   import r12_pkg::*;
(
   input  logic [BYTE_BITS-1:0] upper,
   input  logic [NIB_BITS-1:0]  nibble,
   output logic [PIX_BITS-1:0]  pixel
);

   // upper byte on top, nibble below
   assign pixel = {upper, nibble};

endmodule

// ===== hdl/r12_index_unit.sv =====
// write index counters and plane selection for each accepted item
module r12_index_unit
   import r12_pkg::*;
#(
   parameter int INDEX_BITS = 20
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      frame_start,
   input  cfg_type   cfg,
   output route_type route
);

   logic [INDEX_BITS-1:0] depth_idx_ff, depth_idx_in;
   logic [INDEX_BITS-1:0] ir_cnt_ff, ir_cnt_in;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic                  row_odd_ff, row_odd_in;
   logic [GRP_BITS-1:0]   grp_ff, grp_in;

   logic [INDEX_BITS-1:0] depth_cur, ir_cnt_cur, ir_at, depth_base, at;
   logic [COL_BITS-1:0]   col_cur, width;
   logic                  row_odd_cur, plane;
   logic [GRP_BITS-1:0]   grp_cur;
   logic [COL_BITS:0]     col_sum, col_sub;

   // counters as they stand after an optional frame restart
   always_comb begin
      depth_cur   = frame_start ? '0 : depth_idx_ff;
      ir_cnt_cur  = frame_start ? '0 : ir_cnt_ff;
      col_cur     = frame_start ? '0 : col_ff;
      row_odd_cur = frame_start ? 1'b0 : row_odd_ff;
      grp_cur     = frame_start ? '0 : grp_ff;
   end

   // ir plane address and row width clamp
   assign ir_at = INDEX_BITS'(cfg.ir_plane_base) + ir_cnt_cur;
   assign width = (cfg.frame_width < MIN_WIDTH) ? MIN_WIDTH : cfg.frame_width;
   assign col_sum = {1'b0, col_cur} + (COL_BITS+1)'(2);
   assign col_sub = col_sum - {1'b0, width};

   // per mode routing and counter updates
   always_comb begin
      depth_idx_in = depth_cur;
      ir_cnt_in    = ir_cnt_cur;
      col_in       = col_cur;
      row_odd_in   = row_odd_cur;
      grp_in       = grp_cur;
      depth_base   = depth_cur;
      plane        = 1'b0;
      at           = depth_cur;
      unique case (cfg.mode)
         MODE_DEPTH: begin
            at           = depth_cur;
            depth_idx_in = depth_cur + INDEX_BITS'(2);
         end
         MODE_IR: begin
            plane     = 1'b1;
            at        = ir_at;
            ir_cnt_in = ir_cnt_cur + INDEX_BITS'(2);
         end
         MODE_ALT: begin
            if (row_odd_cur) begin
               plane     = 1'b1;
               at        = ir_at;
               ir_cnt_in = ir_cnt_cur + INDEX_BITS'(2);
            end else begin
               at           = depth_cur;
               depth_idx_in = depth_cur + INDEX_BITS'(2);
            end
            if (col_sum >= {1'b0, width}) begin
               col_in     = col_sub[COL_BITS-1:0];
               row_odd_in = ~row_odd_cur;
            end else begin
               col_in = col_sum[COL_BITS-1:0];
            end
         end
         MODE_RAW: begin
            if (cfg.raw_line_groups == '0) begin
               grp_in = '0;
            end else if (grp_cur >= cfg.raw_line_groups) begin
               depth_base = depth_cur - INDEX_BITS'(cfg.raw_stepback);
               grp_in     = GRP_BITS'(1);
            end else begin
               grp_in = grp_cur + GRP_BITS'(1);
            end
            at           = depth_base;
            depth_idx_in = depth_base + INDEX_BITS'(2);
         end
         default: begin
            at = depth_cur;
         end
      endcase
   end

   assign route.plane      = plane;
   assign route.dest_index = DEST_BITS'(at);

   // counter registers move only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_idx_ff <= '0;
         ir_cnt_ff    <= '0;
         col_ff       <= '0;
         row_odd_ff   <= 1'b0;
         grp_ff       <= '0;
      end else if (advance) begin
         depth_idx_ff <= depth_idx_in;
         ir_cnt_ff    <= ir_cnt_in;
         col_ff       <= col_in;
         row_odd_ff   <= row_odd_in;
         grp_ff       <= grp_in;
      end
   end

endmodule

// ===== hdl/raw12_unpack_plane_router.sv =====
// Raw12 unpacker and plane router. Each item is one packed three-byte group and gives one
// result holding two 12-bit pixels, the target plane and the buffer index of the first pixel.
// Two unpack lanes build the pixels side by side while the index unit picks the destination;
// both are merged into one output register. An item is taken every cycle unless the output
// register is full and rsp_ready is low; throughput is set by the index unit's counter update
// (add and compare on the row and line counters). Counters restart on an item's frame_start
// flag. The user must write registers via the csr port only while idle; it is not enforced.
module raw12_unpack_plane_router
   import r12_pkg::*;
#(
   parameter int INDEX_BITS = 20
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_item_type             req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_item_type             rsp_item,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   cfg_type      cfg_ff;
   route_type    route;
   logic [PIX_BITS-1:0] pix_first, pix_second;
   logic         accept;
   logic         out_valid_ff;
   rsp_item_type out_item_ff, out_item_in;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode            <= MODE_ALT;
         cfg_ff.frame_width     <= 12'd640;
         cfg_ff.ir_plane_base   <= 20'd153600;
         cfg_ff.raw_line_groups <= 12'd336;
         cfg_ff.raw_stepback    <= 4'd4;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:        cfg_ff.mode            <= mode_type'(csr_data[1:0]);
            CSR_FRAME_WIDTH: cfg_ff.frame_width     <= csr_data[COL_BITS-1:0];
            CSR_IR_BASE:     cfg_ff.ir_plane_base   <= csr_data[DEST_BITS-1:0];
            CSR_LINE_GROUPS: cfg_ff.raw_line_groups <= csr_data[GRP_BITS-1:0];
            CSR_STEPBACK:    cfg_ff.raw_stepback    <= csr_data[STEP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // input taken whenever the output register is free or draining
   assign req_ready = ~out_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   // pixel lanes
   r12_unpack_lane u_lane_first (
      .upper  (req_item.byte_a),
      .nibble (req_item.byte_c[NIB_BITS-1:0]),
      .pixel  (pix_first)
   );

   r12_unpack_lane u_lane_second (
      .upper  (req_item.byte_b),
      .nibble (req_item.byte_c[BYTE_BITS-1:NIB_BITS]),
      .pixel  (pix_second)
   );

   // destination index and plane
   r12_index_unit #(
      .INDEX_BITS (INDEX_BITS)
   ) u_index (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .frame_start (req_item.frame_start),
      .cfg         (cfg_ff),
      .route       (route)
   );

   // merge lanes and route into the result
   always_comb begin
      out_item_in.pixel_first  = pix_first;
      out_item_in.pixel_second = pix_second;
      out_item_in.plane        = route.plane;
      out_item_in.dest_index   = route.dest_index;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_ready) begin
         out_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// ===== sim/raw12_route_checker.sv =====
// checker for the raw12 unpack plane router: predicts each result and compares it
module raw12_route_checker
   import r12_pkg::*;
#(
   parameter int INDEX_BITS = 20
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  req_item_type             req_item,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  rsp_item_type             rsp_item,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output int                       mismatch_count,
   output int                       outstanding,
   output int                       checked_count,
   output int                       ir_count,
   output logic [3:0]               modes_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow copy of the registers
   cfg_type cfg;

   // shadow copy of the routing counters
   logic [INDEX_BITS-1:0] depth_write_index;
   logic [INDEX_BITS-1:0] ir_write_count;
   logic [COL_BITS-1:0]   column_count;
   logic                  row_odd;
   logic [GRP_BITS-1:0]   raw_group_count;

   // expected results, oldest first
   rsp_item_type expected_pixels[$];
   rsp_item_type oldest;

   function automatic void clear_counters();
      depth_write_index = '0;
      ir_write_count    = '0;
      column_count      = '0;
      row_odd           = 1'b0;
      raw_group_count   = '0;
   endfunction

   function automatic logic [INDEX_BITS-1:0] take_depth();
      logic [INDEX_BITS-1:0] at;
      at = depth_write_index;
      depth_write_index = depth_write_index + INDEX_BITS'(2);
      return at;
   endfunction

   function automatic logic [INDEX_BITS-1:0] take_ir();
      logic [INDEX_BITS-1:0] at;
      at = INDEX_BITS'(cfg.ir_plane_base + ir_write_count);
      ir_write_count = ir_write_count + INDEX_BITS'(2);
      return at;
   endfunction

   // unpack one group and pick its destination, advancing the counters
   function automatic rsp_item_type route_group(input req_item_type item);
      rsp_item_type          res;
      logic [INDEX_BITS-1:0] at;
      logic [COL_BITS:0]     col_next;
      logic [COL_BITS-1:0]   width;
      if (item.frame_start) begin
         clear_counters();
      end
      res.pixel_first  = {item.byte_a, item.byte_c[3:0]};
      res.pixel_second = {item.byte_b, item.byte_c[7:4]};
      res.plane        = 1'b0;
      case (cfg.mode)
         MODE_DEPTH: begin
            at = take_depth();
         end
         MODE_IR: begin
            res.plane = 1'b1;
            at = take_ir();
         end
         MODE_ALT: begin
            // odd rows to the ir plane, even rows to depth
            width = (cfg.frame_width < MIN_WIDTH) ? MIN_WIDTH : cfg.frame_width;
            if (row_odd) begin
               res.plane = 1'b1;
               at = take_ir();
            end else begin
               at = take_depth();
            end
            col_next = {1'b0, column_count} + (COL_BITS+1)'(2);
            if (col_next >= {1'b0, width}) begin
               col_next = col_next - {1'b0, width};
               row_odd  = ~row_odd;
            end
            column_count = col_next[COL_BITS-1:0];
         end
         default: begin
            // raw lines: step back once a line is full
            if (cfg.raw_line_groups == '0) begin
               raw_group_count = '0;
            end else begin
               if (raw_group_count >= cfg.raw_line_groups) begin
                  depth_write_index = depth_write_index - INDEX_BITS'(cfg.raw_stepback);
                  raw_group_count   = '0;
               end
               raw_group_count = raw_group_count + GRP_BITS'(1);
            end
            at = take_depth();
         end
      endcase
      res.dest_index = DEST_BITS'(at);
      return res;
   endfunction

   function automatic void write_register(input logic [CSR_IDX_BITS-1:0] idx,
                                          input logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         CSR_MODE:        cfg.mode            = mode_type'(value[1:0]);
         CSR_FRAME_WIDTH: cfg.frame_width     = value[COL_BITS-1:0];
         CSR_IR_BASE:     cfg.ir_plane_base   = value[DEST_BITS-1:0];
         CSR_LINE_GROUPS: cfg.raw_line_groups = value[GRP_BITS-1:0];
         CSR_STEPBACK:    cfg.raw_stepback    = value[STEP_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic void report_failure(input string what);
      if (mismatch_count < 10) begin
         $display("%t %s", $realtime, what);
      end
      mismatch_count = mismatch_count + 1;
   endfunction

   // watch the three channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         cfg.mode            = MODE_ALT;
         cfg.frame_width     = 12'd640;
         cfg.ir_plane_base   = 20'd153600;
         cfg.raw_line_groups = 12'd336;
         cfg.raw_stepback    = 4'd4;
         clear_counters();
         expected_pixels.delete();
         mismatch_count = 0;
         checked_count  = 0;
         ir_count       = 0;
         modes_seen     = '0;
         outstanding   <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            write_register(csr_index, csr_data);
         end
         if (req_valid && req_ready) begin
            modes_seen[cfg.mode] = 1'b1;
            expected_pixels.insert(expected_pixels.size(), route_group(req_item));
         end
         if (rsp_valid && rsp_ready) begin
            checked_count = checked_count + 1;
            if (rsp_item.plane === 1'b1) begin
               ir_count = ir_count + 1;
            end
            if (expected_pixels.size() == 0) begin
               report_failure($sformatf(
                  "result with no item waiting: first=%h second=%h plane=%b index=%h",
                  rsp_item.pixel_first, rsp_item.pixel_second, rsp_item.plane,
                  rsp_item.dest_index));
            end else begin
               oldest = expected_pixels.pop_front();
               if (rsp_item.pixel_first  !== oldest.pixel_first  ||
                   rsp_item.pixel_second !== oldest.pixel_second ||
                   rsp_item.plane        !== oldest.plane        ||
                   rsp_item.dest_index   !== oldest.dest_index) begin
                  report_failure($sformatf({"mismatch on result %0d: expected first=%h ",
                     "second=%h plane=%b index=%h, got first=%h second=%h plane=%b index=%h"},
                     checked_count, oldest.pixel_first, oldest.pixel_second, oldest.plane,
                     oldest.dest_index, rsp_item.pixel_first, rsp_item.pixel_second,
                     rsp_item.plane, rsp_item.dest_index));
               end
            end
         end
         outstanding <= expected_pixels.size();
      end
   end

endmodule

// ===== sim/tb.sv =====
// testbench top for the raw12 unpack plane router: clock, reset, stimulus and verdict
module tb;
   import r12_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int INDEX_BITS    = 20;
   localparam int RANDOM_GROUPS = 850;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_LIMIT   = 20000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_item_type             req_item;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_item_type             rsp_item;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   int         mismatch_count;
   int         outstanding;
   int         checked_count;
   int         ir_count;
   logic [3:0] modes_seen;

   // idle percentages of the two sides and the one long receiver hold
   int   req_idle;
   int   rsp_idle;
   logic hold_armed;

   int groups_sent;
   int settings_loaded;

   raw12_unpack_plane_router #(.INDEX_BITS(INDEX_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   raw12_route_checker #(.INDEX_BITS(INDEX_BITS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item       (rsp_item),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .checked_count  (checked_count),
      .ir_count       (ir_count),
      .modes_seen     (modes_seen)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #2ms;
      $display("CHECK FAILED");
      $finish;
   end

   // receiver: random stalls, plus one long hold while the sender keeps pushing
   initial begin : receiver
      logic hold_done;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle);
      end
   end

   function automatic req_item_type make_group(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c, input logic fs);
      req_item_type g;
      g.byte_a      = a;
      g.byte_b      = b;
      g.byte_c      = c;
      g.frame_start = fs;
      return g;
   endfunction

   function automatic req_item_type random_group(input logic force_start);
      return make_group(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), force_start || ($urandom_range(99) < 3));
   endfunction

   // register settings: first two random phases take the extremes
   function automatic cfg_type pick_config(input int phase);
      cfg_type c;
      c.mode = mode_type'($urandom_range(3));
      if (phase == 0) begin
         c.frame_width     = 12'hFFF;
         c.ir_plane_base   = 20'hFFFFF;
         c.raw_line_groups = 12'hFFF;
         c.raw_stepback    = 4'hF;
      end else if (phase == 1) begin
         c.frame_width     = 12'h000;
         c.ir_plane_base   = 20'h00000;
         c.raw_line_groups = 12'h000;
         c.raw_stepback    = 4'h0;
      end else begin
         case ($urandom_range(7))
            0: c.frame_width = 12'($urandom_range(2));
            1: c.frame_width = 12'hFFF;
            2: c.frame_width = 12'hFFE;
            default: c.frame_width = 12'($urandom_range(40, 3));
         endcase
         case ($urandom_range(5))
            0: c.ir_plane_base = 20'h00000;
            1: c.ir_plane_base = 20'hFFFFF;
            default: c.ir_plane_base = 20'($urandom_range(20'hFFFFF));
         endcase
         case ($urandom_range(7))
            0: c.raw_line_groups = 12'h000;
            1: c.raw_line_groups = 12'hFFF;
            2: c.raw_line_groups = 12'h001;
            default: c.raw_line_groups = 12'($urandom_range(30, 2));
         endcase
         c.raw_stepback = 4'($urandom_range(15));
      end
      return c;
   endfunction

   // one group on the input channel, with random gaps in front
   task automatic send_group(input req_item_type item);
      while (req_idle != 0 && $urandom_range(99) < req_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (!req_ready);
      groups_sent++;
   endtask

   // one register write; the caller lowers csr_valid after the last one
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_config(input cfg_type c);
      write_reg(CSR_MODE,        CSR_DATA_BITS'(c.mode));
      write_reg(CSR_FRAME_WIDTH, CSR_DATA_BITS'(c.frame_width));
      write_reg(CSR_IR_BASE,     CSR_DATA_BITS'(c.ir_plane_base));
      write_reg(CSR_LINE_GROUPS, CSR_DATA_BITS'(c.raw_line_groups));
      write_reg(CSR_STEPBACK,    CSR_DATA_BITS'(c.raw_stepback));
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // stop sending and wait for every expected result, up to the drain limit, then idle
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      cfg_type c;
      int      random_sent;
      int      phase;
      int      count;
      req_valid   = 1'b0;
      req_item    = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_MODE;
      csr_data    = '0;
      req_idle    = 36;
      rsp_idle    = 68;
      hold_armed  = 1'b0;
      groups_sent = 0;
      settings_loaded = 0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, alternating rows: byte and nibble extremes
      send_group(make_group(8'h00, 8'h00, 8'h00, 1'b1));
      send_group(make_group(8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_group(make_group(8'hFF, 8'h00, 8'h0F, 1'b0));
      send_group(make_group(8'h00, 8'hFF, 8'hF0, 1'b0));
      drain();

      // narrow frame: a width of zero behaves as two
      c.mode            = MODE_ALT;
      c.frame_width     = 12'd0;
      c.ir_plane_base   = 20'd1000;
      c.raw_line_groups = 12'd336;
      c.raw_stepback    = 4'd4;
      load_config(c);
      repeat (4) send_group(random_group(1'b0));
      drain();

      // width shrunk mid-row: counter left above the new width
      c.frame_width = 12'd6;
      load_config(c);
      repeat (2) send_group(random_group(1'b0));
      drain();
      c.frame_width = 12'd2;
      load_config(c);
      repeat (4) send_group(random_group(1'b0));
      drain();

      // ir plane near the top of the index range wraps
      c.mode          = MODE_IR;
      c.ir_plane_base = 20'hFFFFE;
      load_config(c);
      send_group(random_group(1'b1));
      repeat (2) send_group(random_group(1'b0));
      drain();

      // raw lines of one group with the widest step-back wrap below zero
      c.mode            = MODE_RAW;
      c.raw_line_groups = 12'd1;
      c.raw_stepback    = 4'd15;
      load_config(c);
      send_group(random_group(1'b1));
      repeat (3) send_group(random_group(1'b0));
      drain();

      // zero line length: no step-back
      c.raw_line_groups = 12'd0;
      load_config(c);
      repeat (3) send_group(random_group(1'b0));
      drain();

      // depth only, counters carried over from raw mode
      c.mode = MODE_DEPTH;
      load_config(c);
      repeat (2) send_group(random_group(1'b0));
      drain();

      // random phases under the three idle profiles
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_GROUPS) begin
         if (random_sent < RANDOM_GROUPS / 3) begin
            req_idle = 36;
            rsp_idle = 68;
         end else if (random_sent < 2 * RANDOM_GROUPS / 3) begin
            req_idle = 68;
            rsp_idle = 36;
         end else begin
            req_idle   = 0;
            rsp_idle   = 0;
            hold_armed = 1'b1;
         end
         c = pick_config(phase);
         load_config(c);
         count = $urandom_range(100, 40);
         for (int i = 0; i < count; i++) begin
            send_group(random_group(i == 0 && $urandom_range(1) == 1));
            random_sent++;
         end
         drain();
         phase++;
      end

      repeat (8) @(posedge clock);
      $display("covered %0d groups over %0d register settings, mode mask %b",
               groups_sent, settings_loaded, modes_seen);
      $display("%0d results checked, %0d routed to the ir plane, %0d mismatches",
               checked_count, ir_count, mismatch_count);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== raw12_unpack_plane_router.f =====
hdl/r12_pkg.sv
hdl/r12_unpack_lane.sv
hdl/r12_index_unit.sv
hdl/raw12_unpack_plane_router.sv
sim/raw12_route_checker.sv
sim/tb.sv
